// ===== rtl/core/sapq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

	localparam int CAPACITY = 8;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VAL_W    = 32;
	localparam int STAT_W   = 2;
	localparam int OCNT_W   = 4;
	localparam int OUT_W    = 40;

	localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_array_priority_queue_top.sv =====
// Sorted-array max-priority queue, CAPACITY signed 32-bit entries.
// Slave channel: s_tuser is the op (0 insert s_tdata, 1 remove largest),
// s_tdata is the value. A transfer occurs when tvalid and tready are high.
// Master channel: one result per input item, m_tdata packed from bit 0:
// removed_value[31:0], status[33:32], entry_count[37:34], zeros above.
// Status 0 ok, 1 insert dropped on full, 2 remove on empty (returns the
// most negative value). Inserts return zero in removed_value.
// After the input transfer the controller passes through S_EXEC, which
// registers the result into the output register and raises m_tvalid.
// The controller takes an item in S_IDLE, then does the parallel
// compare-and-shift over all cells in S_EXEC, where it takes no new item.
// Equal values: the newest is removed first.
// While a result waits in the output register s_tready stays low; a new
// item can transfer in the same cycle that the receiver takes the result.
// Reset (arst_n low) empties the queue; stored values need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // value[31:0]
	input  wire logic        s_tuser,   // op[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata    // removed_value[31:0], status[33:32],
	                                    // entry_count[37:34], zero[39:38]
);
	import sapq_pkg::*;

	cmd_t                cmd;
	logic [VAL_W-1:0]    removed_value;
	status_t             status;
	logic [OCNT_W-1:0]   entry_count;

	sapq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sapq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (s_tuser),
		.value         (s_tdata),
		.removed_value (removed_value),
		.status        (status),
		.entry_count   (entry_count)
	);

	assign m_tdata = {(OUT_W - VAL_W - STAT_W - OCNT_W)'(0), entry_count,
		status, removed_value};

endmodule

`default_nettype wire

// ===== rtl/core/sapq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapq_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output sapq_pkg::cmd_t    cmd
);
	import sapq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// take a new item only when the result slot is free or drains this cycle
	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && m_tready)
						out_valid_q <= 1'b0;
					if (s_tvalid && s_tready)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sapq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sapq_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sapq_pkg::cmd_t                    cmd,
	input  wire logic                              op,
	input  wire logic [sapq_pkg::VAL_W-1:0]        value,
	output logic      [sapq_pkg::VAL_W-1:0]        removed_value,
	output sapq_pkg::status_t                      status,
	output logic      [sapq_pkg::OCNT_W-1:0]       entry_count
);
	import sapq_pkg::*;

	logic                     op_q;
	logic signed [VAL_W-1:0]  value_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [VAL_W-1:0]  store_q [CAPACITY];

	logic [VAL_W-1:0]         removed_q;
	status_t                  status_q;
	logic [CNT_W-1:0]         res_cnt_q;

	logic [CAPACITY-1:0]      gt;
	logic [CAPACITY-1:0]      shift_in;
	logic [CAPACITY-1:0]      wr_en;
	logic signed [VAL_W-1:0]  prev [CAPACITY];
	logic signed [VAL_W-1:0]  nxt  [CAPACITY];
	logic                     full;
	logic                     empty;
	logic [IDX_W-1:0]         top_idx;
	logic                     ins_en;
	logic                     rem_en;
	logic [CNT_W-1:0]         count_nxt;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign top_idx = IDX_W'(count_q - CNT_W'(1));
	assign ins_en  = cmd.exec && (op_q == OP_INSERT) && !full;
	assign rem_en  = cmd.exec && (op_q == OP_REMOVE) && !empty;

	// every occupied cell compares against the new value in parallel
	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			gt[i] = (CNT_W'(i) < count_q) && (store_q[i] > value_q);
		shift_in[0] = 1'b0;
		prev[0]     = value_q;
		for (int i = 1; i < CAPACITY; i++) begin
			shift_in[i] = gt[i-1];
			prev[i]     = store_q[i-1];
		end
		for (int i = 0; i < CAPACITY; i++) begin
			nxt[i]   = shift_in[i] ? prev[i] : value_q;
			wr_en[i] = shift_in[i] || gt[i] || (CNT_W'(i) == count_q);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_en)
			count_nxt = count_q + CNT_W'(1);
		else if (rem_en)
			count_nxt = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			value_q <= value;
		end
		if (ins_en) begin
			for (int i = 0; i < CAPACITY; i++)
				if (wr_en[i])
					store_q[i] <= nxt[i];
		end
		if (cmd.exec) begin
			res_cnt_q <= count_nxt;
			if (op_q == OP_INSERT) begin
				removed_q <= '0;
				status_q  <= full ? ST_FULL : ST_OK;
			end else if (empty) begin
				removed_q <= INT_MIN;
				status_q  <= ST_EMPTY;
			end else begin
				removed_q <= store_q[top_idx];
				status_q  <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = OCNT_W'(res_cnt_q);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

import sapq_pkg::*;

typedef struct {
	logic signed [VAL_W-1:0]  removed;
	logic        [STAT_W-1:0] status;
	logic        [OCNT_W-1:0] count;
} pq_reply_t;

// Mirror of the queue contents; predicts one reply per accepted op.
class sorted_queue_mirror;
	logic signed [VAL_W-1:0] cells [CAPACITY];
	int                      fill;
	pq_reply_t               awaited [$];
	int                      mismatches;

	function new();
		fill = 0;
		mismatches = 0;
	endfunction

	function void accept_op(logic op, logic signed [VAL_W-1:0] val);
		pq_reply_t r;
		int        pos;
		r.removed = '0;
		r.status  = ST_OK;
		if (op == OP_INSERT) begin
			if (fill >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				// larger entries move up; equal ones stay below the new value
				pos = fill;
				while (pos > 0 && cells[pos-1] > val) begin
					cells[pos] = cells[pos-1];
					pos--;
				end
				cells[pos] = val;
				fill++;
			end
		end else if (fill == 0) begin
			r.status  = ST_EMPTY;
			r.removed = INT_MIN;
		end else begin
			fill--;
			r.removed = cells[fill];
		end
		r.count = fill[OCNT_W-1:0];
		awaited.push_back(r);
	endfunction

	function void check_reply(logic [OUT_W-1:0] word);
		pq_reply_t e;
		if (awaited.size() == 0) begin
			$display("%0t: result %h with nothing expected", $time, word);
			mismatches++;
			return;
		end
		e = awaited.pop_front();
		if (word[31:0] !== e.removed) begin
			$display("%0t: removed_value expected %0d actual %0d",
				$time, e.removed, $signed(word[31:0]));
			mismatches++;
		end
		if (word[33:32] !== e.status) begin
			$display("%0t: status expected %0d actual %0d", $time, e.status, word[33:32]);
			mismatches++;
		end
		if (word[37:34] !== e.count) begin
			$display("%0t: entry_count expected %0d actual %0d",
				$time, e.count, word[37:34]);
			mismatches++;
		end
	endfunction
endclass

module testbench;

	localparam int QUIET_LIMIT = 2000;
	localparam logic [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [VAL_W-1:0]  s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	int send_idle_pct  = 25;
	int recv_stall_pct = 66;
	int quiet_cycles   = 0;

	sorted_queue_mirror mirror = new();

	sorted_array_priority_queue_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check every transfer, then pick next tready
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			mirror.check_reply(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_op(input logic op, input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		do
			@(posedge clk);
		while (!s_tready);
		mirror.accept_op(op, $signed(val));
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 60)
			return $urandom;
		if (sel < 80)
			return VAL_W'($signed($urandom_range(6)) - 3);
		case ($urandom_range(5))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return INT_MIN + 1;
			3: return INT_MAX - 1;
			4: return '0;
			default: return '1;
		endcase
	endfunction

	// insert/remove mix drifts so the queue swings between empty and full
	task automatic run_random(input int n_items);
		int unsigned insert_pct;
		insert_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0)
				insert_pct = $urandom_range(20, 80);
			if ($urandom_range(99) < insert_pct)
				send_op(OP_INSERT, pick_value());
			else
				send_op(OP_REMOVE, $urandom);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_INSERT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty, extremes, duplicates, full, drain, empty again
		send_op(OP_REMOVE, $urandom);
		send_op(OP_INSERT, '0);
		send_op(OP_INSERT, INT_MAX);
		send_op(OP_INSERT, INT_MIN);
		send_op(OP_INSERT, '1);
		send_op(OP_INSERT, 32'd5);
		send_op(OP_INSERT, 32'd5);
		send_op(OP_INSERT, 32'd5);
		send_op(OP_INSERT, 32'd1);
		send_op(OP_INSERT, 32'd42);
		send_op(OP_INSERT, INT_MAX);
		repeat (CAPACITY) send_op(OP_REMOVE, $urandom);
		send_op(OP_REMOVE, '0);
		send_op(OP_REMOVE, '1);
		send_op(OP_INSERT, INT_MIN);
		send_op(OP_REMOVE, '1);
		send_op(OP_INSERT, INT_MAX);
		send_op(OP_REMOVE, '0);

		run_random(600);
		send_idle_pct  = 66;
		recv_stall_pct = 25;
		run_random(600);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(650);

		s_tvalid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sapq_pkg.sv
rtl/core/sapq_ctrl.sv
rtl/core/sapq_datapath.sv
rtl/core/sorted_array_priority_queue_top.sv
verif/testbench.sv
